// ----- src/stcf_pkg.sv -----
// Package for the serial transport connection engine.
// Shared types, codes and constants; no dependencies.
package stcf_pkg;

  localparam int unsigned MAX_PAYLOAD   = 240;
  localparam int unsigned FIRST_CONN_ID = 1;
  localparam int unsigned HEADER_BYTES  = 4;
  localparam int unsigned DGRAM_HDR     = 2;
  localparam int unsigned QDEPTH        = 2;

  localparam logic [2:0] OP_PACKET = 3'd0;
  localparam logic [2:0] OP_TICK   = 3'd1;
  localparam logic [2:0] OP_CONN   = 3'd2;
  localparam logic [2:0] OP_LISTEN = 3'd3;
  localparam logic [2:0] OP_DISC   = 3'd4;
  localparam logic [2:0] OP_DATA   = 3'd5;
  localparam logic [2:0] OP_DGRAM  = 3'd6;

  localparam logic [3:0] PK_SYN    = 4'd0;
  localparam logic [3:0] PK_SYNACK = 4'd1;
  localparam logic [3:0] PK_ACK    = 4'd2;
  localparam logic [3:0] PK_FIN    = 4'd3;
  localparam logic [3:0] PK_FINACK = 4'd4;
  localparam logic [3:0] PK_DATA   = 4'd5;
  localparam logic [3:0] PK_DACK   = 4'd6;
  localparam logic [3:0] PK_DNACK  = 4'd7;
  localparam logic [3:0] PK_KA     = 4'd8;
  localparam logic [3:0] PK_KAACK  = 4'd9;
  localparam logic [3:0] PK_DGRAM  = 4'd10;

  localparam logic [2:0] RK_STATUS = 3'd0;
  localparam logic [2:0] RK_PACKET = 3'd1;
  localparam logic [2:0] RK_EVENT  = 3'd2;
  localparam logic [2:0] RK_DATA   = 3'd3;
  localparam logic [2:0] RK_DGRAM  = 3'd4;

  localparam logic [2:0] SC_OK      = 3'd0;
  localparam logic [2:0] SC_STATE   = 3'd1;
  localparam logic [2:0] SC_NOTCONN = 3'd2;
  localparam logic [2:0] SC_LEN     = 3'd3;
  localparam logic [2:0] SC_DROP    = 3'd4;

  localparam logic [1:0] EV_CONNECTED    = 2'd0;
  localparam logic [1:0] EV_DISCONNECTED = 2'd1;
  localparam logic [1:0] EV_TIMEOUT      = 2'd2;
  localparam logic [1:0] EV_RESET        = 2'd3;

  localparam logic [1:0] CFG_KA    = 2'd0;
  localparam logic [1:0] CFG_RESP  = 2'd1;
  localparam logic [1:0] CFG_RETRY = 2'd2;

  typedef enum logic [2:0] {
    ST_DISC, ST_LISTEN, ST_CONNECTING, ST_CONNECTED, ST_DISCONNECTING, ST_ERROR
  } conn_st_t;

  typedef enum logic [1:0] {CL_PACKET, CL_TICK, CL_REQ, CL_NONE} cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [2:0] op;
    logic [31:0] now;
    logic [3:0] kind;
    logic [7:0] conn;
    logic [7:0] seq;
    logic [7:0] bytes;
    logic       short_pkt;
    logic       len_bad;
    logic       dgram_bad;
  } cmd_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [2:0] status_code;
    logic [3:0] tx_kind;
    logic [7:0] tx_conn;
    logic [7:0] tx_seq;
    logic [7:0] tx_len;
    logic [1:0] event_code;
    logic       last_of_run;
  } res_t;

endpackage

// ----- src/stcf_front.sv -----
// Front end: accepts input transfers, classifies them and checks lengths.
// Depends on stcf_pkg.
module stcf_front import stcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_now_ms,
  input  logic [3:0]  in_rx_kind,
  input  logic [7:0]  in_rx_conn,
  input  logic [7:0]  in_rx_seq,
  input  logic [7:0]  in_byte_count,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  cmd_t                 mem_r [QDEPTH];
  logic                 wp_r, rp_r;
  logic [1:0]           cnt_r;
  logic                 push;
  cmd_t                 c;

  always_comb begin
    c.op        = in_operation;
    c.now       = in_now_ms;
    c.kind      = in_rx_kind;
    c.conn      = in_rx_conn;
    c.seq       = in_rx_seq;
    c.bytes     = in_byte_count;
    c.short_pkt = in_byte_count < 8'(HEADER_BYTES);
    c.len_bad   = (in_byte_count == 8'd0) || (in_byte_count > 8'(MAX_PAYLOAD));
    c.dgram_bad = in_byte_count > 8'(MAX_PAYLOAD);
    case (in_operation)
      OP_PACKET: c.cls = CL_PACKET;
      OP_TICK:   c.cls = CL_TICK;
      OP_CONN, OP_LISTEN, OP_DISC, OP_DATA, OP_DGRAM: c.cls = CL_REQ;
      default:   c.cls = CL_NONE;
    endcase
  end

  assign in_stall = (cnt_r == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QDEPTH)) else $error("queue overflow");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(QDEPTH) && !q_pop) |=> in_stall) else $error("full not stalled");
`endif

endmodule

// ----- src/stcf_back.sv -----
// Back end: connection state machine; computes a run of up to three results
// per command and drains it one result per cycle while out_stall is low. Depends on stcf_pkg.
module stcf_back import stcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [19:0] cfg_data,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output res_t        out_res
);

  logic [19:0] ka_r, resp_r;
  logic [3:0]  rlim_r;
  conn_st_t    st_r, st_nxt;
  logic [7:0]  cid_r, cid_nxt, own_r, own_nxt, peer_r, peer_nxt;
  logic [3:0]  rtr_r, rtr_nxt;
  logic        aw_r, aw_nxt;
  logic [31:0] lsend_r, lsend_nxt, lalive_r, lalive_nxt;

  res_t        run_r [4];
  res_t        run_nxt [4];
  logic [2:0]  n_r, n_nxt;
  logic [1:0]  pos_r;
  logic        busy_r;
  logic [2:0]  sc;
  logic [2:0]  n;
  logic [31:0] idle, since;
  logic [21:0] ka3;
  cmd_t        m;
  logic        adv;

  function automatic res_t mk(logic [2:0] k, logic [2:0] s, logic [3:0] t,
                              logic [7:0] cc, logic [7:0] ss, logic [7:0] l,
                              logic [1:0] e);
    res_t r;
    r.result_kind = k; r.status_code = s; r.tx_kind = t; r.tx_conn = cc;
    r.tx_seq = ss; r.tx_len = l; r.event_code = e; r.last_of_run = 1'b0;
    return r;
  endfunction

  assign m     = q_cmd;
  assign q_pop = q_valid && (!busy_r || (adv && out_res.last_of_run));
  assign idle  = m.now - lalive_r;
  assign since = m.now - lsend_r;
  assign ka3   = {2'b0, ka_r} + {1'b0, ka_r, 1'b0};

  always_comb begin
    st_nxt = st_r; cid_nxt = cid_r; own_nxt = own_r; peer_nxt = peer_r;
    rtr_nxt = rtr_r; aw_nxt = aw_r; lsend_nxt = lsend_r; lalive_nxt = lalive_r;
    sc = SC_OK; n = 3'd0;
    for (int i = 0; i < 4; i++) run_nxt[i] = mk(RK_STATUS, SC_OK, 4'd0, 8'd0, 8'd0, 8'd0, 2'd0);
    case (m.cls)
      CL_PACKET: begin
        if (m.short_pkt) sc = SC_DROP;
        else begin
          case (m.kind)
            PK_SYN: begin
              if (st_r != ST_LISTEN && st_r != ST_CONNECTED) sc = SC_DROP;
              else begin
                peer_nxt = m.seq;
                if (st_r == ST_CONNECTED) begin
                  if (m.conn == 8'd0) begin
                    st_nxt = ST_DISC;
                    run_nxt[0] = mk(RK_EVENT, SC_OK, 4'd0, 8'd0, 8'd0, 8'd0, EV_RESET);
                    n = 3'd1;
                  end
                end else if (m.conn == 8'd0) begin
                  st_nxt = ST_CONNECTING; aw_nxt = 1'b1; own_nxt = m.now[7:0];
                  cid_nxt = (cid_r == 8'hFF) ? 8'(FIRST_CONN_ID) : cid_r + 8'd1;
                  run_nxt[0] = mk(RK_PACKET, SC_OK, PK_SYNACK, cid_nxt, m.now[7:0],
                                  8'd0, 2'd0);
                  n = 3'd1; lsend_nxt = m.now;
                end
              end
            end
            PK_SYNACK: begin
              if (st_r != ST_CONNECTING) sc = SC_DROP;
              else begin
                cid_nxt = m.conn; peer_nxt = m.seq;
                run_nxt[0] = mk(RK_PACKET, SC_OK, PK_ACK, m.conn, m.seq, 8'd0, 2'd0);
                run_nxt[1] = mk(RK_EVENT, SC_OK, 4'd0, 8'd0, 8'd0, 8'd0, EV_CONNECTED);
                n = 3'd2;
                st_nxt = ST_CONNECTED; aw_nxt = 1'b0; rtr_nxt = 4'd0;
                lalive_nxt = m.now;
              end
            end
            PK_ACK: begin
              if (st_r != ST_CONNECTING && st_r != ST_DISCONNECTING) sc = SC_DROP;
              else if (m.conn == cid_r) begin
                if (st_r == ST_CONNECTING) begin
                  if (m.seq == own_r) begin
                    st_nxt = ST_CONNECTED; aw_nxt = 1'b0; rtr_nxt = 4'd0;
                    lalive_nxt = m.now;
                    run_nxt[0] = mk(RK_EVENT, SC_OK, 4'd0, 8'd0, 8'd0, 8'd0,
                                    EV_CONNECTED);
                    n = 3'd1;
                  end
                end else begin
                  st_nxt = ST_DISC; aw_nxt = 1'b0; cid_nxt = 8'd0;
                  run_nxt[0] = mk(RK_EVENT, SC_OK, 4'd0, 8'd0, 8'd0, 8'd0,
                                  EV_DISCONNECTED);
                  n = 3'd1;
                end
              end
            end
            PK_FIN: begin
              if (st_r != ST_CONNECTED) sc = SC_DROP;
              else if (m.conn == cid_r) begin
                run_nxt[0] = mk(RK_PACKET, SC_OK, PK_ACK, m.conn, own_r, 8'd0, 2'd0);
                run_nxt[1] = mk(RK_PACKET, SC_OK, PK_FIN, cid_r, own_r, 8'd0, 2'd0);
                n = 3'd2; lsend_nxt = m.now;
                st_nxt = ST_DISCONNECTING; aw_nxt = 1'b1;
              end
            end
            PK_FINACK: begin
              if (st_r != ST_DISCONNECTING) sc = SC_DROP;
              else if (m.conn == cid_r) begin
                st_nxt = ST_DISC; aw_nxt = 1'b0;
                run_nxt[0] = mk(RK_EVENT, SC_OK, 4'd0, 8'd0, 8'd0, 8'd0,
                                EV_DISCONNECTED);
                n = 3'd1;
              end
            end
            PK_DATA: begin
              if (st_r != ST_CONNECTED || m.conn != cid_r) sc = SC_DROP;
              else if (m.seq != peer_r) begin
                run_nxt[0] = mk(RK_PACKET, SC_OK, PK_DNACK, cid_r, m.seq, 8'd0, 2'd0);
                n = 3'd1; sc = SC_DROP;
              end else begin
                run_nxt[0] = mk(RK_DATA, SC_OK, 4'd0, 8'd0, 8'd0,
                                m.bytes - 8'(HEADER_BYTES), 2'd0);
                run_nxt[1] = mk(RK_PACKET, SC_OK, PK_DACK, cid_r, m.seq, 8'd0, 2'd0);
                n = 3'd2; peer_nxt = peer_r + 8'd1;
              end
            end
            PK_DACK, PK_DNACK: if (st_r != ST_CONNECTED) sc = SC_DROP;
            PK_KA: begin
              if (st_r != ST_CONNECTED || m.conn != cid_r) sc = SC_DROP;
              else begin
                run_nxt[0] = mk(RK_PACKET, SC_OK, PK_KAACK, cid_r, 8'd0, 8'd0, 2'd0);
                n = 3'd1;
              end
            end
            PK_KAACK: begin
              if (st_r != ST_CONNECTED || m.conn != cid_r) sc = SC_DROP;
              else lalive_nxt = m.now;
            end
            PK_DGRAM: begin
              if (st_r == ST_ERROR) sc = SC_DROP;
              else begin
                run_nxt[0] = mk(RK_DGRAM, SC_OK, 4'd0, 8'd0, 8'd0,
                                m.bytes - 8'(DGRAM_HDR), 2'd0);
                n = 3'd1;
              end
            end
            default: sc = SC_DROP;
          endcase
        end
      end
      CL_TICK: begin
        if (st_r == ST_CONNECTED) begin
          if (idle > {10'd0, ka3}) begin
            st_nxt = ST_DISCONNECTING;
            run_nxt[0] = mk(RK_EVENT, SC_OK, 4'd0, 8'd0, 8'd0, 8'd0, EV_TIMEOUT);
            n = 3'd1;
          end else if (idle > {12'd0, ka_r}) begin
            run_nxt[0] = mk(RK_PACKET, SC_OK, PK_KA, cid_r, 8'd0, 8'd0, 2'd0);
            n = 3'd1;
          end
        end else if (st_r == ST_CONNECTING) begin
          if (aw_r && since > {12'd0, resp_r}) begin
            if (rtr_r < rlim_r) begin
              rtr_nxt = rtr_r + 4'd1;
              run_nxt[0] = mk(RK_PACKET, SC_OK, PK_SYN, 8'd0, own_r, 8'd0, 2'd0);
              n = 3'd1; lsend_nxt = m.now;
            end else begin
              st_nxt = ST_ERROR;
              run_nxt[0] = mk(RK_EVENT, SC_OK, 4'd0, 8'd0, 8'd0, 8'd0, EV_TIMEOUT);
              n = 3'd1;
            end
          end
        end else if (st_r == ST_DISCONNECTING) begin
          if (aw_r && since > {12'd0, resp_r}) begin
            st_nxt = ST_DISC; aw_nxt = 1'b0; cid_nxt = 8'd0;
            run_nxt[0] = mk(RK_EVENT, SC_OK, 4'd0, 8'd0, 8'd0, 8'd0, EV_DISCONNECTED);
            n = 3'd1;
          end
        end
      end
      CL_REQ: begin
        case (m.op)
          OP_CONN: begin
            if (st_r == ST_CONNECTED) sc = SC_OK;
            else if (st_r != ST_DISC) sc = SC_STATE;
            else begin
              st_nxt = ST_CONNECTING; rtr_nxt = 4'd0; aw_nxt = 1'b1;
              own_nxt = m.now[7:0]; peer_nxt = 8'd0;
              run_nxt[0] = mk(RK_PACKET, SC_OK, PK_SYN, 8'd0, m.now[7:0], 8'd0, 2'd0);
              n = 3'd1; lsend_nxt = m.now;
            end
          end
          OP_LISTEN: begin
            if (st_r == ST_LISTEN || st_r == ST_CONNECTED) sc = SC_OK;
            else if (st_r != ST_DISC) sc = SC_STATE;
            else begin
              st_nxt = ST_LISTEN; own_nxt = 8'd0; peer_nxt = 8'd0;
            end
          end
          OP_DISC: begin
            if (st_r != ST_CONNECTED) sc = SC_NOTCONN;
            else begin
              st_nxt = ST_DISCONNECTING; aw_nxt = 1'b1;
              run_nxt[0] = mk(RK_PACKET, SC_OK, PK_FIN, cid_r, own_r, 8'd0, 2'd0);
              n = 3'd1; lsend_nxt = m.now;
            end
          end
          OP_DATA: begin
            if (m.len_bad) sc = SC_LEN;
            else if (st_r != ST_CONNECTED) sc = SC_STATE;
            else begin
              run_nxt[0] = mk(RK_PACKET, SC_OK, PK_DATA, cid_r, own_r, m.bytes, 2'd0);
              n = 3'd1; aw_nxt = 1'b1; lsend_nxt = m.now; own_nxt = own_r + 8'd1;
            end
          end
          OP_DGRAM: begin
            if (m.dgram_bad) sc = SC_LEN;
            else begin
              run_nxt[0] = mk(RK_PACKET, SC_OK, PK_DGRAM, 8'd0, 8'd0, m.bytes, 2'd0);
              n = 3'd1;
            end
          end
          default: sc = SC_OK;
        endcase
      end
      default: sc = SC_OK;
    endcase
    run_nxt[n[1:0]] = mk(RK_STATUS, sc, 4'd0, 8'd0, 8'd0, 8'd0, 2'd0);
    run_nxt[n[1:0]].last_of_run = 1'b1;
    n_nxt = n;
  end

  assign out_valid = busy_r;
  assign out_res   = run_r[pos_r];
  assign adv       = busy_r && !out_stall;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 4; i++) run_r[i] <= run_nxt[i];
      n_r <= n_nxt;
    end
    if (!rst_n) begin
      ka_r <= 20'd1000; resp_r <= 20'd3000; rlim_r <= 4'd3;
      st_r <= ST_DISC; cid_r <= 8'd0; own_r <= 8'd0; peer_r <= 8'd0;
      rtr_r <= 4'd0; aw_r <= 1'b0; lsend_r <= 32'd0; lalive_r <= 32'd0;
      busy_r <= 1'b0; pos_r <= 2'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_KA:    ka_r <= cfg_data;
          CFG_RESP:  resp_r <= cfg_data;
          CFG_RETRY: rlim_r <= cfg_data[3:0];
          default:   ;
        endcase
      end
      if (q_pop) begin
        st_r <= st_nxt; cid_r <= cid_nxt; own_r <= own_nxt; peer_r <= peer_nxt;
        rtr_r <= rtr_nxt; aw_r <= aw_nxt; lsend_r <= lsend_nxt;
        lalive_r <= lalive_nxt;
        busy_r <= 1'b1; pos_r <= 2'd0;
      end else if (adv) begin
        if (out_res.last_of_run) busy_r <= 1'b0;
        else pos_r <= pos_r + 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ({1'b0, pos_r} <= n_r)) else $error("run position past end");
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && {1'b0, pos_r} == n_r) |-> out_res.last_of_run)
    else $error("run end without last flag");
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_ERROR |=> st_r == ST_ERROR) else $error("left error state");
`endif

endmodule

// ----- src/serial_transport_connection_fsm_unit.sv -----
// Top level of the serial transport connection engine.
// Depends on stcf_pkg, stcf_front and stcf_back.
// Each input transfer is one event and yields a run of one to three result
// transfers, the last flagged by last_of_run. A two-entry queue decouples
// input from the state machine; an idle back end takes a queued event,
// then emits its run one result per cycle while out_stall is low, and
// takes the next queued event in the cycle the last result transfers, so
// under load the runs follow one another with no gap.
module serial_transport_connection_fsm_unit import stcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_now_ms,
  input  logic [3:0]  in_rx_kind,
  input  logic [7:0]  in_rx_conn,
  input  logic [7:0]  in_rx_seq,
  input  logic [7:0]  in_byte_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_result_kind,
  output logic [2:0]  out_status_code,
  output logic [3:0]  out_tx_kind,
  output logic [7:0]  out_tx_conn,
  output logic [7:0]  out_tx_seq,
  output logic [7:0]  out_tx_len,
  output logic [1:0]  out_event_code,
  output logic        out_last_of_run
);

  logic q_valid, q_pop;
  cmd_t q_cmd;
  res_t res;

  stcf_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_operation, .in_now_ms,
    .in_rx_kind, .in_rx_conn, .in_rx_seq, .in_byte_count,
    .q_valid, .q_cmd, .q_pop
  );

  stcf_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_idx(cfg_index), .cfg_data,
    .q_valid, .q_cmd, .q_pop, .out_valid, .out_stall, .out_res(res)
  );

  assign out_result_kind = res.result_kind;
  assign out_status_code = res.status_code;
  assign out_tx_kind     = res.tx_kind;
  assign out_tx_conn     = res.tx_conn;
  assign out_tx_seq      = res.tx_seq;
  assign out_tx_len      = res.tx_len;
  assign out_event_code  = res.event_code;
  assign out_last_of_run = res.last_of_run;

endmodule
